@@ rtl/integer_to_ascii_converter_assert.svh @@
// Assertion macros for the integer to ASCII converter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef INTEGER_TO_ASCII_CONVERTER_ASSERT_SVH
`define INTEGER_TO_ASCII_CONVERTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define I2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/i2a_pkg.sv @@
// Shared types, constants and helpers of the integer to ASCII converter.
// No dependencies.
`default_nettype none

package i2a_pkg;

  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned OPERAND_W  = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [1:0] OP_SDEC    = 2'd0;
  localparam logic [1:0] OP_UDEC    = 2'd1;
  localparam logic [1:0] OP_HEX     = 2'd2;
  localparam logic [1:0] OP_HEX_ALT = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_OFS = 8'h57;  // 'a' - 10
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic                 start;
    logic                 hex;
    logic [OPERAND_W-1:0] mag;
  } dab_req_t;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_load_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] ext;
    ext = {{(8 - DIGIT_W){1'b0}}, d};
    if (d < DIGIT_W'(10)) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A_OFS + ext;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_ascii_converter.sv @@
// Integer to ASCII converter: top level with control sequencer.
// Depends on i2a_pkg, i2a_dabble, i2a_emit and the assertion macro header.
//
// Usage:
//   Input stream: tdata carries the 64-bit operand; tuser carries the opcode
//   (0 signed decimal, 1 unsigned decimal, 2 or 3 lower-case hex) and the
//   wide flag (0 uses the low 32 bits, 1 uses all 64 bits).
//   Output stream: one ASCII character per transfer in tdata, most
//   significant digit first, with a leading '-' for negative signed values;
//   tlast marks the final character of each number.
//   Timing: one request at a time. The operand is shifted through the digit
//   converter one bit per cycle, and the digits then go to the emitter. Leading
//   zeros are then skipped one digit per cycle, a final step ends the skip, and
//   one character leaves per cycle (1 to 20 characters) while the receiver is
//   ready; the bit-serial shift dominates the time a request takes. The next
//   request is accepted once the sequencer is back in idle after the final
//   character enters the output register, even if the receiver has not taken it.
//   A stalled receiver holds the output register and pauses the emitter.
//   Reset clears the sequencer and the output valid; no request is pending.
`default_nettype none
`include "integer_to_ascii_converter_assert.svh"

module integer_to_ascii_converter #(
  parameter int unsigned MaxDigits = i2a_pkg::MAX_DIGITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] value
  input  wire logic [2:0]  s_axis_tuser_i,   // [1:0] opcode, [2] wide
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] character
  output logic             m_axis_tlast_o
);

  localparam int unsigned OpW   = i2a_pkg::OPERAND_W;
  localparam int unsigned HalfW = i2a_pkg::HALF_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic                neg_q, neg_d;
  logic                accept;
  logic [1:0]          opcode;
  logic                wide;
  logic                is_signed;
  logic                is_hex;
  logic [OpW-1:0]      ext;
  logic                negative;
  i2a_pkg::dab_req_t   dab_req;
  i2a_pkg::emit_load_t emit_load;
  logic                dab_done;
  logic                emit_busy;
  logic [MaxDigits*i2a_pkg::DIGIT_W-1:0] digits;

  assign opcode    = s_axis_tuser_i[1:0];
  assign wide      = s_axis_tuser_i[2];
  assign is_signed = (opcode == i2a_pkg::OP_SDEC);
  assign is_hex    = (opcode == i2a_pkg::OP_HEX) || (opcode == i2a_pkg::OP_HEX_ALT);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Narrow operands are sign- or zero-extended from bit 31.
  always_comb begin
    if (wide) begin
      ext = s_axis_tdata_i;
    end else if (is_signed) begin
      ext = {{(OpW - HalfW){s_axis_tdata_i[HalfW-1]}}, s_axis_tdata_i[HalfW-1:0]};
    end else begin
      ext = {{(OpW - HalfW){1'b0}}, s_axis_tdata_i[HalfW-1:0]};
    end
  end

  assign negative      = is_signed && ext[OpW-1];
  assign dab_req.start = accept;
  assign dab_req.hex   = is_hex;
  assign dab_req.mag   = negative ? (~ext + OpW'(1)) : ext;

  assign emit_load.load = dab_done;
  assign emit_load.neg  = neg_q;

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CONV;
          neg_d   = negative;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  i2a_dabble #(
    .MaxDigits (MaxDigits)
  ) u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (dab_req),
    .done_o   (dab_done),
    .digits_o (digits)
  );

  i2a_emit #(
    .MaxDigits (MaxDigits)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit_load),
    .digits_i (digits),
    .busy_o   (emit_busy),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .char_o   (m_axis_tdata_o),
    .last_o   (m_axis_tlast_o)
  );

  `I2A_ASSERT(a_accept_starts_conv, accept |=> (state_q == ST_CONV), "accept did not start conversion")
  `I2A_ASSERT(a_done_in_conv, dab_done |-> (state_q == ST_CONV), "converter done outside conversion")
  `I2A_ASSERT(a_idle_emit_quiet, (state_q == ST_IDLE) |-> !emit_busy, "emitter busy while idle")
  `I2A_ASSERT_ALWAYS(a_no_accept_busy, (accept && rst_ni) |-> (!emit_busy && !dab_done), "request accepted while busy")

endmodule

`default_nettype wire

@@ rtl/i2a_dabble.sv @@
// Bit-serial binary to digit converter (shift and add-3 for decimal, plain shift for hex), one bit per cycle.
// Depends on i2a_pkg.
`default_nettype none

module i2a_dabble #(
  parameter int unsigned MaxDigits = i2a_pkg::MAX_DIGITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire i2a_pkg::dab_req_t                    req_i,
  output logic                                      done_o,
  output logic [MaxDigits*i2a_pkg::DIGIT_W-1:0]     digits_o
);

  localparam int unsigned DigW = i2a_pkg::DIGIT_W;
  localparam int unsigned BcdW = MaxDigits * DigW;
  localparam int unsigned OpW  = i2a_pkg::OPERAND_W;
  localparam int unsigned CntW = $clog2(OpW + 1);

  logic [OpW-1:0]  bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            hex_q, hex_d;

  // Correct every digit of 5 or more before the shift; hex shifts plainly.
  always_comb begin
    logic [DigW-1:0] dg;
    adj = bcd_q;
    for (int i = 0; i < int'(MaxDigits); i++) begin
      dg = bcd_q[i*DigW +: DigW];
      if (!hex_q && dg >= DigW'(5)) begin
        adj[i*DigW +: DigW] = dg + DigW'(3);
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    hex_d  = hex_q;
    done_d = 1'b0;
    if (req_i.start) begin
      bin_d  = req_i.mag;
      bcd_d  = '0;
      cnt_d  = CntW'(OpW);
      busy_d = 1'b1;
      hex_d  = req_i.hex;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[OpW-1]};
      bin_d = {bin_q[OpW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    hex_q <= hex_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

@@ rtl/i2a_emit.sv @@
// Character emitter: skips leading zeros, sends sign and digits, MSD first.
// Depends on i2a_pkg.
`default_nettype none

module i2a_emit #(
  parameter int unsigned MaxDigits = i2a_pkg::MAX_DIGITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire i2a_pkg::emit_load_t                  load_i,
  input  wire logic [MaxDigits*i2a_pkg::DIGIT_W-1:0] digits_i,
  output logic                                      busy_o,
  output logic                                      tvalid_o,
  input  wire logic                                 tready_i,
  output logic [7:0]                                char_o,
  output logic                                      last_o
);

  localparam int unsigned DigW = i2a_pkg::DIGIT_W;
  localparam int unsigned BcdW = MaxDigits * DigW;
  localparam int unsigned LeftW = $clog2(MaxDigits + 1);

  logic [BcdW-1:0]  dig_q, dig_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             neg_q, neg_d;
  logic             skip_q, skip_d;
  logic             busy_q, busy_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       ochar_q, ochar_d;
  logic             olast_q, olast_d;
  logic [DigW-1:0]  top_dig;
  logic             out_free;

  assign top_dig  = dig_q[BcdW-1 -: DigW];
  assign out_free = !ovalid_q || tready_i;

  always_comb begin
    dig_d    = dig_q;
    left_d   = left_q;
    neg_d    = neg_q;
    skip_d   = skip_q;
    busy_d   = busy_q;
    ovalid_d = ovalid_q && !tready_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (load_i.load) begin
      dig_d  = digits_i;
      left_d = LeftW'(MaxDigits);
      neg_d  = load_i.neg;
      skip_d = 1'b1;
      busy_d = 1'b1;
    end else if (busy_q && skip_q) begin
      // drop leading zeros, keep at least one digit
      if (top_dig == '0 && left_q != LeftW'(1)) begin
        dig_d  = {dig_q[BcdW-DigW-1:0], {DigW{1'b0}}};
        left_d = left_q - LeftW'(1);
      end else begin
        skip_d = 1'b0;
      end
    end else if (busy_q && out_free) begin
      ovalid_d = 1'b1;
      if (neg_q) begin
        ochar_d = i2a_pkg::CHAR_MINUS;
        olast_d = 1'b0;
        neg_d   = 1'b0;
      end else begin
        ochar_d = i2a_pkg::digit_char(top_dig);
        olast_d = (left_q == LeftW'(1));
        dig_d   = {dig_q[BcdW-DigW-1:0], {DigW{1'b0}}};
        left_d  = left_q - LeftW'(1);
        if (left_q == LeftW'(1)) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      skip_q   <= 1'b0;
      neg_q    <= 1'b0;
      left_q   <= '0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      skip_q   <= skip_d;
      neg_q    <= neg_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign busy_o   = busy_q;
  assign tvalid_o = ovalid_q;
  assign char_o   = ochar_q;
  assign last_o   = olast_q;

endmodule

`default_nettype wire

@@ test/tb_integer_to_ascii_converter.sv @@
// Self-checking testbench for integer_to_ascii_converter: drives operand requests
// on the input stream and checks every character against the directed text or a local formatter.
// Depends on i2a_pkg and the converter RTL only.
`timescale 1ns / 1ps

module tb_integer_to_ascii_converter;

  localparam int unsigned STALL_LIMIT = 5000;  // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 150;
  localparam int unsigned REPORT_MAX  = 10;
  localparam string       DIGIT_SET   = "0123456789abcdef";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } ascii_beat_t;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  op;
    logic        wide;
    string       text;   // empty: take the formatter's answer
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // [63:0] value
  logic [2:0]  s_tuser = '0;  // [1:0] opcode, [2] wide
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // [7:0] character
  logic        m_tlast;

  ascii_beat_t pending_chars[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_off_request = 1'b0;

  directed_row_t directed_rows [25] = '{
    '{64'h0, i2a_pkg::OP_SDEC, 1'b1, "0"},
    '{64'h0, i2a_pkg::OP_UDEC, 1'b0, "0"},
    '{64'h0, i2a_pkg::OP_HEX, 1'b1, "0"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_UDEC, 1'b1, "18446744073709551615"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_SDEC, 1'b1, "-1"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_HEX, 1'b1, "ffffffffffffffff"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_SDEC, 1'b1, "-9223372036854775808"},
    '{64'h7FFF_FFFF_FFFF_FFFF, i2a_pkg::OP_SDEC, 1'b1, "9223372036854775807"},
    '{64'h0000_0000_8000_0000, i2a_pkg::OP_SDEC, 1'b0, "-2147483648"},
    '{64'hFFFF_FFFF_7FFF_FFFF, i2a_pkg::OP_SDEC, 1'b0, "2147483647"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_UDEC, 1'b0, "4294967295"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_HEX, 1'b0, "ffffffff"},
    '{64'hFFFF_FFFF_FFFF_FFFF, i2a_pkg::OP_HEX_ALT, 1'b1, "ffffffffffffffff"},
    '{64'hDEAD_BEEF_0123_4567, i2a_pkg::OP_HEX_ALT, 1'b0, "1234567"},
    '{64'h0123_4567_89AB_CDEF, i2a_pkg::OP_HEX, 1'b1, "123456789abcdef"},
    '{64'd9, i2a_pkg::OP_UDEC, 1'b1, "9"},
    '{64'd10, i2a_pkg::OP_SDEC, 1'b0, "10"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_UDEC, 1'b1, "9223372036854775808"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_HEX, 1'b1, "8000000000000000"},
    '{64'hFFFF_FFFF_8000_0000, i2a_pkg::OP_SDEC, 1'b1, "-2147483648"},
    '{64'h8000_0000_0000_0000, i2a_pkg::OP_SDEC, 1'b0, "0"},
    '{64'h0000_0001_0000_0000, i2a_pkg::OP_SDEC, 1'b0, "0"},
    '{64'd1000000000000000000, i2a_pkg::OP_UDEC, 1'b1, ""},
    '{64'h5555_5555_5555_5555, i2a_pkg::OP_SDEC, 1'b1, ""},
    '{64'hAAAA_AAAA_AAAA_AAAA, i2a_pkg::OP_SDEC, 1'b1, ""}
  };

  integer_to_ascii_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic void push_text(string text);
    ascii_beat_t beat;
    for (int i = 0; i < text.len(); i++) begin
      beat.ch   = text[i];
      beat.last = (i == text.len() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // Format one operand the way the converter should: sign, then digits MSD first.
  function automatic void format_operand(logic [63:0] value, logic [1:0] op, logic wide);
    logic [63:0] mag;
    logic [63:0] radix;
    logic        neg;
    logic        signed_mode;
    byte         digits[$];
    ascii_beat_t beat;
    signed_mode = (op == i2a_pkg::OP_SDEC);
    mag = value;
    if (!wide) begin
      mag = {32'h0, value[31:0]};
      if (signed_mode && value[31]) mag[63:32] = '1;
    end
    neg = signed_mode && mag[63];
    if (neg) mag = ~mag + 64'd1;
    radix = op[1] ? 64'd16 : 64'd10;
    do begin
      digits.push_front(DIGIT_SET[int'(mag % radix)]);
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      beat.ch   = i2a_pkg::CHAR_MINUS;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
    end
    foreach (digits[i]) begin
      beat.ch   = digits[i];
      beat.last = (i == digits.size() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  function automatic logic [63:0] random_operand(logic wide);
    logic [63:0] value;
    logic [63:0] pow;
    pow = 64'd1;
    case ($urandom_range(0, 6))
      0: value = {$urandom, $urandom};
      1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: value = 64'($urandom_range(0, 20));
      3: begin
        // step just around a power of ten
        repeat ($urandom_range(0, 19)) pow = pow * 64'd10;
        value = pow + 64'($urandom_range(0, 2)) - 64'd1;
      end
      4: value = 64'h0 - 64'($urandom_range(1, 20));
      5: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      default: value = {$urandom, 32'h0 - 32'($urandom_range(1, 20))};
    endcase
    if (!wide && $urandom_range(0, 1)) value[63:32] = $urandom;
    return value;
  endfunction

  // Ready is stable between edges, so look at it at the falling edge.
  task automatic offer_request(logic [63:0] value, logic [1:0] op, logic wide, string text);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= {wide, op};
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (text.len() != 0) push_text(text);
    else format_operand(value, op, wide);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items, int unsigned tx_pct, int unsigned rx_pct,
                           bit press);
    logic [1:0] op;
    logic       wide;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) begin
      // stop the receiver for a long stretch while requests keep coming
      if (press && (i == 3)) hold_off_request = 1'b1;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      op   = 2'($urandom_range(0, 3));
      wide = 1'($urandom_range(0, 1));
      offer_request(random_operand(wide), op, wide, "");
    end
    drain_results();
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Handshake signals only change at the rising edge; sample them at the falling edge before it.
  always @(negedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected character 0x%02h last=%0b", m_tdata, m_tlast);
      end else begin
        if (pending_chars[0].ch !== m_tdata || pending_chars[0].last !== m_tlast) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("character mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     pending_chars[0].ch, pending_chars[0].last, m_tdata, m_tlast);
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    rx_stall_pct = 20;
    foreach (directed_rows[i])
      offer_request(directed_rows[i].value, directed_rows[i].op, directed_rows[i].wide,
                    directed_rows[i].text);
    drain_results();

    run_phase(70, 0, 0, 1'b0);
    run_phase(70, 55, 0, 1'b0);
    run_phase(70, 0, 55, 1'b0);
    run_phase(70, 36, 36, 1'b0);
    run_phase(75, 0, 0, 1'b1);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_dabble.sv
rtl/i2a_emit.sv
rtl/integer_to_ascii_converter.sv
test/tb_integer_to_ascii_converter.sv
